[hdl/hight_pkg.sv]
// ----------------------------------------------------------------------------
// HIGHT cipher package
// Shared types, constants and byte functions for the HIGHT pipeline.
// ----------------------------------------------------------------------------
package hight_pkg;

    localparam int ROUND_COUNT  = 32;
    localparam int SUBKEY_COUNT = 4 * ROUND_COUNT;
    localparam logic [6:0] DELTA_SEED = 7'h5A;

    typedef logic [7:0] t_byte;
    typedef t_byte [7:0] t_state;   // byte i at bits 8i+7:8i
    typedef t_byte [3:0] t_rkey;    // four subkeys of one round
    typedef logic [6:0] t_delta_tab [SUBKEY_COUNT];

    typedef enum logic {
        OP_ENC = 1'b0,
        OP_DEC = 1'b1
    } t_op;

    // One pipeline slot: valid bit, direction and the eight state bytes
    typedef struct packed {
        logic   valid;
        t_op    op;
        t_state data;
    } t_stage;

    function automatic t_byte fn0(input t_byte x);
        return {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[0], x[7:1]};
    endfunction

    function automatic t_byte fn1(input t_byte x);
        return {x[4:0], x[7:5]} ^ {x[3:0], x[7:4]} ^ {x[1:0], x[7:2]};
    endfunction

    // Delta constants from the LFSR x^7 + x^3 + 1
    function automatic t_delta_tab make_delta();
        t_delta_tab tab;
        logic [6:0] d;
        d = DELTA_SEED;
        for (int n = 0; n < SUBKEY_COUNT; n++) begin
            tab[n] = d;
            d = {d[3] ^ d[0], d[6:1]};
        end
        return tab;
    endfunction

    localparam t_delta_tab DELTA = make_delta();

    // Master key byte that feeds subkey n
    function automatic logic [3:0] key_index(input int n);
        int i;
        int j;
        int half;
        i    = (n >> 4) & 7;
        j    = n & 7;
        half = (n >> 3) & 1;
        return 4'(((j + 8 - i) & 7) + 8 * half);
    endfunction

endpackage

[hdl/hight_round.sv]
// ----------------------------------------------------------------------------
// HIGHT round stage
// One registered round, encrypt or decrypt as the word's opcode selects.
// ----------------------------------------------------------------------------
module hight_round (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hight_pkg::t_stage i_stage,
    input  hight_pkg::t_rkey  i_enc_key,
    input  hight_pkg::t_rkey  i_dec_key,
    output hight_pkg::t_stage o_stage
);
    import hight_pkg::*;

    t_stage r_stage;
    t_state n_data;
    t_state x;
    t_rkey  k;

    always_comb begin
        x = i_stage.data;
        n_data = x;
        if (i_stage.op == OP_DEC) begin
            k = i_dec_key;
            n_data[0] = x[1];
            n_data[2] = x[3];
            n_data[4] = x[5];
            n_data[6] = x[7];
            n_data[1] = x[2] - (fn1(x[1]) ^ k[0]);
            n_data[3] = x[4] ^ (fn0(x[3]) + k[1]);
            n_data[5] = x[6] - (fn1(x[5]) ^ k[2]);
            n_data[7] = x[0] ^ (fn0(x[7]) + k[3]);
        end else begin
            k = i_enc_key;
            n_data[1] = x[0];
            n_data[3] = x[2];
            n_data[5] = x[4];
            n_data[7] = x[6];
            n_data[0] = x[7] ^ (fn0(x[6]) + k[3]);
            n_data[2] = x[1] + (fn1(x[0]) ^ k[0]);
            n_data[4] = x[3] ^ (fn0(x[2]) + k[1]);
            n_data[6] = x[5] + (fn1(x[4]) ^ k[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage.op   <= i_stage.op;
        r_stage.data <= n_data;
    end

    assign o_stage = r_stage;

endmodule

[hdl/hight_block_cipher.sv]
// ----------------------------------------------------------------------------
// HIGHT block cipher, 64-bit block, 128-bit key
// Fully unrolled pipeline: whitening, 32 round stages, final whitening.
// ----------------------------------------------------------------------------
// Usage: drive start with a word on i_block_in and i_opcode (0 encrypt,
// 1 decrypt); it is taken at any clock edge where busy is low, which is every
// cycle once reset is released, so one word may enter per cycle. Each word
// leaves on o_block_out after the last pipeline register, with o_valid high
// for one cycle; there is no backpressure, so sample it then or lose it.
// A word passes through the pipeline: one input whitening stage, one register
// per round for the 32 rounds, and one output register holding the final
// whitening. Encrypt and decrypt words may be mixed freely. The key lives in
// two 64-bit APB registers (key_low at 0x0, key_high at 0x8, byte i at
// bits 8i+7:8i); write them only while no word is in flight.
// ----------------------------------------------------------------------------
module hight_block_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_block_in,
    input  logic        i_opcode,
    // result channel
    output logic        o_valid,
    output logic [63:0] o_block_out,
    // APB key registers
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import hight_pkg::*;

    // ------------------------------------------------------------------
    // Key registers
    // ------------------------------------------------------------------
    logic [63:0] r_key_low;
    logic [63:0] r_key_high;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    // bit 3 of the byte address selects the register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (w_cfg_wr) begin
            if (paddr[3]) begin
                r_key_high <= pwdata;
            end else begin
                r_key_low <= pwdata;
            end
        end
    end

    assign prdata = paddr[3] ? r_key_high : r_key_low;

    // ------------------------------------------------------------------
    // Key schedule as logic: master key bytes, whitening keys, round subkeys.
    // The user, not the block, keeps the key static while words are in flight.
    // ------------------------------------------------------------------
    t_byte w_mk [16];
    t_byte w_wk [8];

    always_comb begin
        for (int n = 0; n < 8; n++) begin
            w_mk[n]     = r_key_low[8*n +: 8];
            w_mk[n + 8] = r_key_high[8*n +: 8];
        end
        for (int n = 0; n < 4; n++) begin
            w_wk[n]     = w_mk[n + 12];
            w_wk[n + 4] = w_mk[n];
        end
    end

    // Round stage s uses round s going forward and round 31-s going back
    t_rkey w_enc_key [ROUND_COUNT];
    t_rkey w_dec_key [ROUND_COUNT];

    for (genvar s = 0; s < ROUND_COUNT; s++) begin : g_skey
        for (genvar t = 0; t < 4; t++) begin : g_byte
            localparam int EN = 4 * s + t;
            localparam int DN = 4 * (ROUND_COUNT - 1 - s) + t;
            assign w_enc_key[s][t] = w_mk[key_index(EN)] + {1'b0, DELTA[EN]};
            assign w_dec_key[s][t] = w_mk[key_index(DN)] + {1'b0, DELTA[DN]};
        end
    end

    // ------------------------------------------------------------------
    // Command accept and input whitening
    // ------------------------------------------------------------------
    logic   w_accept;
    t_stage r_pre;
    t_state n_pre_data;
    t_state w_in;

    // Hold off commands only while reset is applied
    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;
    assign w_in     = i_block_in;

    always_comb begin
        n_pre_data = w_in;
        if (t_op'(i_opcode) == OP_DEC) begin
            n_pre_data[1] = w_in[0] - w_wk[4];
            n_pre_data[2] = w_in[1];
            n_pre_data[3] = w_in[2] ^ w_wk[5];
            n_pre_data[4] = w_in[3];
            n_pre_data[5] = w_in[4] - w_wk[6];
            n_pre_data[6] = w_in[5];
            n_pre_data[7] = w_in[6] ^ w_wk[7];
            n_pre_data[0] = w_in[7];
        end else begin
            n_pre_data[0] = w_in[0] + w_wk[0];
            n_pre_data[2] = w_in[2] ^ w_wk[1];
            n_pre_data[4] = w_in[4] + w_wk[2];
            n_pre_data[6] = w_in[6] ^ w_wk[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre.valid <= 1'b0;
        end else begin
            r_pre.valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre.op   <= t_op'(i_opcode);
        r_pre.data <= n_pre_data;
    end

    // ------------------------------------------------------------------
    // Round pipeline: one registered round per stage
    // ------------------------------------------------------------------
    t_stage w_stage [ROUND_COUNT + 1];

    assign w_stage[0] = r_pre;

    for (genvar s = 0; s < ROUND_COUNT; s++) begin : g_round
        hight_round u_round (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_stage   (w_stage[s]),
            .i_enc_key (w_enc_key[s]),
            .i_dec_key (w_dec_key[s]),
            .o_stage   (w_stage[s + 1])
        );
    end

    // ------------------------------------------------------------------
    // Output whitening and result register
    // ------------------------------------------------------------------
    t_stage w_last;
    t_state n_out_data;
    logic   r_out_valid;
    t_state r_out_data;

    assign w_last = w_stage[ROUND_COUNT];

    always_comb begin
        n_out_data = w_last.data;
        if (w_last.op == OP_DEC) begin
            n_out_data[0] = w_last.data[0] - w_wk[0];
            n_out_data[2] = w_last.data[2] ^ w_wk[1];
            n_out_data[4] = w_last.data[4] - w_wk[2];
            n_out_data[6] = w_last.data[6] ^ w_wk[3];
        end else begin
            n_out_data[0] = w_last.data[1] + w_wk[4];
            n_out_data[1] = w_last.data[2];
            n_out_data[2] = w_last.data[3] ^ w_wk[5];
            n_out_data[3] = w_last.data[4];
            n_out_data[4] = w_last.data[5] + w_wk[6];
            n_out_data[5] = w_last.data[6];
            n_out_data[6] = w_last.data[7] ^ w_wk[7];
            n_out_data[7] = w_last.data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_valid     = r_out_valid;
    assign o_block_out = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // every accepted word shows up exactly at the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(w_accept, ROUND_COUNT + 2))
        else $error("result strobe does not match accepted word");

    // an accepted word enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_pre.valid)
        else $error("accepted word not captured");

    // the last round stage always drains to the result register
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.valid |=> r_out_valid)
        else $error("word dropped at output");

    // direction travels unchanged through the first round stage
    a_op_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stage[1].valid |-> w_stage[1].op == $past(r_pre.op))
        else $error("opcode corrupted in pipeline");

endmodule

[test/hight_block_cipher_tb.sv]
// ----------------------------------------------------------------------------
// HIGHT block cipher testbench
// Drives 64-bit words through the cipher pipeline in both directions under a
// series of keys written over APB, predicts each result from an independent
// HIGHT model kept in a scoreboard class, and checks every result word in
// order. Idle gaps of random length fall on the command side in most random phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Scoreboard: holds its own copy of the key, turns each accepted word into the
// expected result word, and compares result words in arrival order.
class cipher_ledger;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [63:0] pending_blocks[$];
    int          errors;

    function new();
        key_lo = '0;
        key_hi = '0;
        errors = 0;
    endfunction

    // Count a failure; report only the first ten
    function void flag(string msg);
        errors++;
        if (errors <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function logic [7:0] rol8(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function logic [7:0] mix0(input logic [7:0] x);
        return rol8(x, 1) ^ rol8(x, 2) ^ rol8(x, 7);
    endfunction

    function logic [7:0] mix1(input logic [7:0] x);
        return rol8(x, 3) ^ rol8(x, 4) ^ rol8(x, 6);
    endfunction

    // Full HIGHT encrypt or decrypt of one block under the held key
    function logic [63:0] hight_crypt(input logic [63:0] blk, input hight_pkg::t_op op);
        logic [7:0]  mk[16];
        logic [7:0]  wk[8];
        logic [7:0]  sk[128];
        logic [7:0]  x[8];
        logic [7:0]  y[8];
        logic [6:0]  d;
        logic [63:0] res;
        int          idx;
        int          kb;
        for (int n = 0; n < 8; n++) begin
            mk[n]     = key_lo[8*n +: 8];
            mk[n + 8] = key_hi[8*n +: 8];
            x[n]      = blk[8*n +: 8];
        end
        for (int n = 0; n < 4; n++) begin
            wk[n]     = mk[n + 12];
            wk[n + 4] = mk[n];
        end
        // subkeys: rotated master key byte plus the LFSR delta
        d = 7'h5A;
        for (int n = 0; n < 128; n++) begin
            idx   = (((n & 7) + 8 - ((n >> 4) & 7)) & 7) + 8 * ((n >> 3) & 1);
            sk[n] = mk[idx] + {1'b0, d};
            d     = {d[3] ^ d[0], d[6:1]};
        end
        if (op == hight_pkg::OP_ENC) begin
            x[0] = x[0] + wk[0];
            x[2] = x[2] ^ wk[1];
            x[4] = x[4] + wk[2];
            x[6] = x[6] ^ wk[3];
            for (int r = 0; r < 32; r++) begin
                kb   = 4 * r;
                y[1] = x[0];
                y[3] = x[2];
                y[5] = x[4];
                y[7] = x[6];
                y[0] = x[7] ^ (mix0(x[6]) + sk[kb + 3]);
                y[2] = x[1] + (mix1(x[0]) ^ sk[kb]);
                y[4] = x[3] ^ (mix0(x[2]) + sk[kb + 1]);
                y[6] = x[5] + (mix1(x[4]) ^ sk[kb + 2]);
                x    = y;
            end
            y[0] = x[1] + wk[4];
            y[1] = x[2];
            y[2] = x[3] ^ wk[5];
            y[3] = x[4];
            y[4] = x[5] + wk[6];
            y[5] = x[6];
            y[6] = x[7] ^ wk[7];
            y[7] = x[0];
            x    = y;
        end else begin
            y[1] = x[0] - wk[4];
            y[2] = x[1];
            y[3] = x[2] ^ wk[5];
            y[4] = x[3];
            y[5] = x[4] - wk[6];
            y[6] = x[5];
            y[7] = x[6] ^ wk[7];
            y[0] = x[7];
            x    = y;
            for (int r = 31; r >= 0; r--) begin
                kb   = 4 * r;
                y[0] = x[1];
                y[2] = x[3];
                y[4] = x[5];
                y[6] = x[7];
                y[1] = x[2] - (mix1(y[0]) ^ sk[kb]);
                y[3] = x[4] ^ (mix0(y[2]) + sk[kb + 1]);
                y[5] = x[6] - (mix1(y[4]) ^ sk[kb + 2]);
                y[7] = x[0] ^ (mix0(y[6]) + sk[kb + 3]);
                x    = y;
            end
            x[0] = x[0] - wk[0];
            x[2] = x[2] ^ wk[1];
            x[4] = x[4] - wk[2];
            x[6] = x[6] ^ wk[3];
        end
        for (int n = 0; n < 8; n++) begin
            res[8*n +: 8] = x[n];
        end
        return res;
    endfunction

    function void note_block(input logic [63:0] blk, input hight_pkg::t_op op);
        pending_blocks.push_back(hight_crypt(blk, op));
    endfunction

    function void check_block(input logic [63:0] got);
        logic [63:0] want;
        if (pending_blocks.size() == 0) begin
            flag($sformatf("unexpected result word: block_out=%016h", got));
            return;
        end
        want = pending_blocks.pop_front();
        if (got !== want) begin
            flag($sformatf("block_out mismatch: expected %016h, got %016h", want, got));
        end
    endfunction
endclass

module hight_block_cipher_tb;
    import hight_pkg::*;

    localparam int         CLK_PERIOD   = 20;
    localparam logic [3:0] KEY_LOW_ADDR  = 4'h0;
    localparam logic [3:0] KEY_HIGH_ADDR = 4'h8;
    // Longest quiet stretch of a correct run is a long gap plus the trip through the
    // pipeline; this is several times that.
    localparam int         STALL_LIMIT  = 1000;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         RANDOM_WORDS = 450;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    logic [63:0] i_block_in = '0;
    logic        i_opcode   = 1'b0;
    logic        o_valid;
    logic [63:0] o_block_out;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [3:0]  paddr      = '0;
    logic [63:0] pwdata     = '0;
    logic [63:0] prdata;
    logic        pready;

    cipher_ledger ledger = new();

    // Words in the pipeline and quiet cycles, both updated at the clock edge
    int in_flight    = 0;
    int stall_cycles = 0;

    hight_block_cipher i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_block_in  (i_block_in),
        .i_opcode    (i_opcode),
        .o_valid     (o_valid),
        .o_block_out (o_block_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample every handshake at the rising edge, before the block's
    // own updates land, and feed the scoreboard.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        bit took;
        bit gave;
        bit key_wr;
        took   = i_rst_n && start === 1'b1 && busy === 1'b0;
        gave   = i_rst_n && o_valid === 1'b1;
        key_wr = i_rst_n && psel && penable && pwrite && pready === 1'b1;
        // Track the key exactly as the block sees it
        if (key_wr) begin
            if (paddr == KEY_LOW_ADDR) begin
                ledger.key_lo = pwdata;
            end else if (paddr == KEY_HIGH_ADDR) begin
                ledger.key_hi = pwdata;
            end
        end
        if (took) begin
            ledger.note_block(i_block_in, t_op'(i_opcode));
        end
        if (gave) begin
            ledger.check_block(o_block_out);
        end
        in_flight <= in_flight + int'(took) - int'(gave);
        // Any accepted transfer resets the watchdog
        if (took || gave || (i_rst_n && psel && penable && pready === 1'b1)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("** hight_block_cipher: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Present one word and hold it until the block takes it. Leave start high
    // so a back-to-back word keeps the command stream full.
    task automatic send_word(input logic [63:0] blk, input t_op op);
        start      <= 1'b1;
        i_block_in <= blk;
        i_opcode   <= op;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Drop start and hold it low while idling; only call with n > 0
    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drop start and wait until every word in flight has come out
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (in_flight != 0);
    endtask

    // One APB transfer: setup, access, then idle with psel low so the next
    // transfer never drives psel twice in the same step
    task automatic apb_cycle(input logic wr, input logic [3:0] addr,
                             input logic [63:0] wdata, output logic [63:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write a key register and read it back
    task automatic set_key(input logic [3:0] addr, input logic [63:0] value);
        logic [63:0] rd;
        apb_cycle(1'b1, addr, value, rd);
        apb_cycle(1'b0, addr, '0, rd);
        if (rd !== value) begin
            ledger.flag($sformatf("key readback at %h: expected %016h, got %016h",
                                  addr, value, rd));
        end
    endtask

    // ------------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------------

    // Mostly random words; some built from edge bytes
    function automatic logic [63:0] rand_block();
        logic [63:0] b;
        b = {$urandom, $urandom};
        if ($urandom_range(0, 9) >= 7) begin
            for (int n = 0; n < 8; n++) begin
                case ($urandom_range(0, 4))
                    0: b[8*n +: 8] = 8'h00;
                    1: b[8*n +: 8] = 8'hFF;
                    2: b[8*n +: 8] = 8'h80;
                    3: b[8*n +: 8] = 8'h01;
                    default: ;
                endcase
            end
        end
        return b;
    endfunction

    // Keys: all zeros, all ones, one bit set, or random
    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        case ($urandom_range(0, 5))
            0: k = '0;
            1: k = '1;
            2: k = 64'h1 << $urandom_range(0, 63);
            default: k = {$urandom, $urandom};
        endcase
        return k;
    endfunction

    // Gap after a word: mostly none, often short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int count;
        int gap;
        bit burst;
        count = 0;

        // Hold reset, then release
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Key still at its reset value of zero
        send_word('0, OP_ENC);
        send_word('1, OP_ENC);
        send_word('0, OP_DEC);
        send_word('1, OP_DEC);
        drain();

        // Published key 00 11 .. ff; the last word is the matching ciphertext
        set_key(KEY_LOW_ADDR, 64'h7766554433221100);
        set_key(KEY_HIGH_ADDR, 64'hFFEEDDCCBBAA9988);
        send_word('0, OP_ENC);
        send_word(64'h5555555555555555, OP_ENC);
        send_word(64'hAAAAAAAAAAAAAAAA, OP_DEC);
        send_word(64'h0123456789ABCDEF, OP_ENC);
        send_word(64'hF2034FD9AE18F400, OP_DEC);
        drain();

        // All-ones key
        set_key(KEY_LOW_ADDR, '1);
        set_key(KEY_HIGH_ADDR, '1);
        send_word('0, OP_ENC);
        send_word('1, OP_ENC);
        send_word('0, OP_DEC);
        send_word('1, OP_DEC);
        send_word(64'h8000000000000001, OP_ENC);
        send_word(64'h8000000000000001, OP_DEC);
        drain();

        // Change one half only: the new key applies to the very next word
        set_key(KEY_LOW_ADDR, '0);
        send_word(64'h0123456789ABCDEF, OP_ENC);
        send_word(64'h0123456789ABCDEF, OP_DEC);

        // Random phases: maybe rekey while idle, then a run of words, mostly with gaps.
        // Each phase starts by draining, so the sender waits out the pipeline.
        while (count < RANDOM_WORDS) begin
            drain();
            case ($urandom_range(0, 3))
                0: begin
                    set_key(KEY_LOW_ADDR, rand_key());
                    set_key(KEY_HIGH_ADDR, rand_key());
                end
                1: set_key(KEY_LOW_ADDR, rand_key());
                2: set_key(KEY_HIGH_ADDR, rand_key());
                default: ;
            endcase
            // Some phases run back to back with no gaps at all
            burst = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(20, 70)) begin
                send_word(rand_block(), t_op'($urandom_range(0, 1)));
                count++;
                gap = burst ? 0 : pick_gap();
                if (gap != 0) begin
                    idle_for(gap);
                end
            end
        end

        // Drain the pipeline, then wait DRAIN_CYCLES longer for stray words
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (in_flight != 0 || ledger.pending_blocks.size() != 0) begin
            ledger.flag($sformatf("%0d expected result words never arrived",
                                  ledger.pending_blocks.size()));
        end

        if (ledger.errors == 0) begin
            $display("** hight_block_cipher: PASSED **");
        end else begin
            $display("** hight_block_cipher: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/hight_pkg.sv
hdl/hight_round.sv
hdl/hight_block_cipher.sv
test/hight_block_cipher_tb.sv
